// ===== src/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, frame constants and defaults of the radar report frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int GATE_COUNT   = 9;

    localparam logic [7:0] RESOLUTION_RESET = 8'd75;

    localparam logic [31:0] REPORT_HEAD = 32'hF4F3F2F1;
    localparam logic [31:0] REPORT_FOOT = 32'hF8F7F6F5;
    localparam logic [31:0] CMD_HEAD    = 32'hFDFCFBFA;
    localparam logic [31:0] CMD_FOOT    = 32'h04030201;

    localparam logic [7:0] MARK_REPORT = 8'hAA;
    localparam logic [7:0] MARK_TAIL   = 8'h55;
    localparam logic [7:0] MARK_CMD    = 8'h01;
    localparam logic [7:0] MODE_ENG    = 8'h01;

    // frame byte positions, also the read steps of the header pass
    localparam logic [4:0] POS_HEAD_END = 5'd3;
    localparam logic [4:0] POS_MODE     = 5'd6;
    localparam logic [4:0] POS_MARK     = 5'd7;
    localparam logic [4:0] POS_STATE    = 5'd8;
    localparam logic [4:0] POS_MD_LO    = 5'd9;
    localparam logic [4:0] POS_MD_HI    = 5'd10;
    localparam logic [4:0] POS_ME       = 5'd11;
    localparam logic [4:0] POS_SD_LO    = 5'd12;
    localparam logic [4:0] POS_SD_HI    = 5'd13;
    localparam logic [4:0] POS_SE       = 5'd14;
    localparam logic [4:0] POS_DD_LO    = 5'd15;
    localparam logic [4:0] POS_DD_HI    = 5'd16;
    localparam logic [4:0] POS_GATE_A   = 5'd17;
    localparam logic [4:0] POS_GATE_B   = 5'd18;
    localparam logic [4:0] STEP_TAIL_A  = 5'd19;
    localparam logic [4:0] STEP_TAIL_B  = 5'd20;
    localparam logic [4:0] POS_CMD_LAST = 5'd9;

    localparam int GATE_MOVE_BASE  = 19;
    localparam int GATE_STILL_BASE = 28;
    localparam int TAIL_A_BACK     = 6;
    localparam int TAIL_B_BACK     = 5;
    localparam int MIN_REPORT_LEN  = 12;
    localparam int MIN_CMD_LEN     = 10;
    localparam int FOOT_LEN        = 4;

    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_GATE    = 2'd1,
        KIND_ACK_OK  = 2'd2,
        KIND_ACK_BAD = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT,
        S_GATE_MOVE,
        S_GATE_STILL,
        S_GATE_OUT
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tgt_status;
        logic        presence;
        logic [15:0] move_dist;
        logic [7:0]  move_pwr;
        logic [15:0] still_dist;
        logic [7:0]  still_pwr;
        logic [15:0] detect_dist;
        logic        engineering;
        logic [15:0] max_range_cm;
        logic [3:0]  gate_index;
        logic        last;
    } t_result;

    function automatic logic [7:0] head_byte(input logic [31:0] pat, input logic [1:0] idx);
        return pat[8 * (3 - idx) +: 8];
    endfunction

endpackage

// ===== src/radar_report_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// radar_report_frame_parser_core
// Serial frame parser: stores received bytes, detects report and command
// footers and emits summary, gate energy and acknowledgment transactions.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while no footer completes
// a footer byte starts a store read pass of 10 (command) or 21 (report) reads
// first result (ack or summary) is registered after the read pass, drain and emit states; emit waits on stall
// each gate result passes gate move, gate still and gate out, one store read port sets the pace
// reset: fill count cleared, all store valid bits cleared, reads zero
// ----------------------------------------------------------------------------
module radar_report_frame_parser_core #(
    parameter int BUFFER_BYTES = rfp_pkg::BUFFER_BYTES,
    parameter int GATE_COUNT   = rfp_pkg::GATE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tgt_status,
    output logic        o_presence,
    output logic [15:0] o_move_dist,
    output logic [7:0]  o_move_pwr,
    output logic [15:0] o_still_dist,
    output logic [7:0]  o_still_pwr,
    output logic [15:0] o_detect_dist,
    output logic        o_engineering,
    output logic [15:0] o_max_range_cm,
    output logic [3:0]  o_gate_index,
    output logic        o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]       r_resolution;
    rfp_pkg::t_result w_result;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [7:0]       w_mem_wdata;
    logic             w_mem_re;
    logic [AW-1:0]    w_mem_raddr;
    logic [7:0]       w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= rfp_pkg::RESOLUTION_RESET;
        end else if (i_cfg_we) begin
            r_resolution <= i_cfg_data;
        end
    end

    rfp_frame_store #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    rfp_seq #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .GATE_COUNT   (GATE_COUNT),
        .AW           (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .o_in_stall   (o_in_stall),
        .i_resolution (r_resolution),
        .o_out_valid  (o_out_valid),
        .o_result     (w_result),
        .i_out_stall  (i_out_stall),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    assign o_kind         = w_result.kind;
    assign o_tgt_status   = w_result.tgt_status;
    assign o_presence     = w_result.presence;
    assign o_move_dist    = w_result.move_dist;
    assign o_move_pwr     = w_result.move_pwr;
    assign o_still_dist   = w_result.still_dist;
    assign o_still_pwr    = w_result.still_pwr;
    assign o_detect_dist  = w_result.detect_dist;
    assign o_engineering  = w_result.engineering;
    assign o_max_range_cm = w_result.max_range_cm;
    assign o_gate_index   = w_result.gate_index;
    assign o_last         = w_result.last;

endmodule

// ===== src/rfp_frame_store.sv =====
// ----------------------------------------------------------------------------
// rfp_frame_store
// Frame byte memory with one write and one registered read port; entries not
// written since reset read as zero.
// ----------------------------------------------------------------------------
module rfp_frame_store #(
    parameter int BUFFER_BYTES = rfp_pkg::BUFFER_BYTES,
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]              r_mem [BUFFER_BYTES];
    logic [BUFFER_BYTES-1:0] r_valid;
    logic [7:0]              r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rfp_seq.sv =====
// ----------------------------------------------------------------------------
// rfp_seq
// Byte intake, footer detection and the read sequencer that validates a
// frame from the store and produces the result transactions.
// ----------------------------------------------------------------------------
module rfp_seq #(
    parameter int BUFFER_BYTES = rfp_pkg::BUFFER_BYTES,
    parameter int GATE_COUNT   = rfp_pkg::GATE_COUNT,
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_rx_byte,
    output logic             o_in_stall,
    input  logic [7:0]       i_resolution,
    output logic             o_out_valid,
    output rfp_pkg::t_result o_result,
    input  logic             i_out_stall,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [7:0]       i_mem_rdata
);

    rfp_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_fill, n_fill;
    logic [23:0]      r_tail, n_tail;
    logic [AW-1:0]    r_len, n_len;
    logic             r_is_cmd, n_is_cmd;
    logic             r_ok, n_ok;
    logic [4:0]       r_step, n_step;
    logic [4:0]       r_cap_step, n_cap_step;
    logic             r_cap_vld, n_cap_vld;
    logic [3:0]       r_gate, n_gate;
    logic             r_out_valid, n_out_valid;

    logic             r_eng, n_eng;
    logic [7:0]       r_ts, n_ts;
    logic [15:0]      r_md, n_md;
    logic [7:0]       r_me, n_me;
    logic [15:0]      r_sd, n_sd;
    logic [7:0]       r_se, n_se;
    logic [15:0]      r_dd, n_dd;
    logic [7:0]       r_g_a, n_g_a;
    logic [7:0]       r_g_b, n_g_b;
    logic [7:0]       r_move, n_move;
    rfp_pkg::t_result r_out, n_out;

    logic             w_accept;
    logic             w_out_free;
    logic [AW-1:0]    w_new_len;
    logic [31:0]      w_new_tail;
    logic [7:0]       w_gate_max;
    logic [15:0]      w_range;
    logic [4:0]       w_last_step;
    logic [AW-1:0]    w_step_addr;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_new_len   = r_fill + AW'(1);
    assign w_new_tail  = {r_tail, i_rx_byte};
    assign w_gate_max  = (r_g_a > r_g_b) ? r_g_a : r_g_b;
    assign w_range     = 16'(w_gate_max) * 16'(i_resolution);
    assign w_last_step = r_is_cmd ? rfp_pkg::POS_CMD_LAST : rfp_pkg::STEP_TAIL_B;

    always_comb begin
        if (r_step == rfp_pkg::STEP_TAIL_A) begin
            w_step_addr = r_len - AW'(rfp_pkg::TAIL_A_BACK);
        end else if (r_step == rfp_pkg::STEP_TAIL_B) begin
            w_step_addr = r_len - AW'(rfp_pkg::TAIL_B_BACK);
        end else begin
            w_step_addr = AW'(r_step);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_tail      = r_tail;
        n_len       = r_len;
        n_is_cmd    = r_is_cmd;
        n_ok        = r_ok;
        n_step      = r_step;
        n_cap_step  = r_cap_step;
        n_cap_vld   = 1'b0;
        n_gate      = r_gate;
        n_out_valid = r_out_valid && i_out_stall;
        n_eng       = r_eng;
        n_ts        = r_ts;
        n_md        = r_md;
        n_me        = r_me;
        n_sd        = r_sd;
        n_se        = r_se;
        n_dd        = r_dd;
        n_g_a       = r_g_a;
        n_g_b       = r_g_b;
        n_move      = r_move;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fill;
        o_mem_wdata = i_rx_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = w_step_addr;
        o_in_stall  = (r_state != rfp_pkg::S_IDLE);

        // capture of the header pass read data
        if (r_cap_vld) begin
            if (r_cap_step <= rfp_pkg::POS_HEAD_END) begin
                n_ok = r_ok && (i_mem_rdata == rfp_pkg::head_byte(
                    r_is_cmd ? rfp_pkg::CMD_HEAD : rfp_pkg::REPORT_HEAD, r_cap_step[1:0]));
            end
            case (r_cap_step)
                rfp_pkg::POS_MODE:    n_eng = (i_mem_rdata == rfp_pkg::MODE_ENG);
                rfp_pkg::POS_MARK:    n_ok = r_ok && (i_mem_rdata ==
                    (r_is_cmd ? rfp_pkg::MARK_CMD : rfp_pkg::MARK_REPORT));
                rfp_pkg::POS_STATE: begin
                    n_ts = i_mem_rdata;
                    n_ok = r_ok && (!r_is_cmd || i_mem_rdata == 8'h00);
                end
                rfp_pkg::POS_MD_LO: begin
                    n_md[7:0] = i_mem_rdata;
                    n_ok = r_ok && (!r_is_cmd || i_mem_rdata == 8'h00);
                end
                rfp_pkg::POS_MD_HI:   n_md[15:8] = i_mem_rdata;
                rfp_pkg::POS_ME:      n_me = i_mem_rdata;
                rfp_pkg::POS_SD_LO:   n_sd[7:0] = i_mem_rdata;
                rfp_pkg::POS_SD_HI:   n_sd[15:8] = i_mem_rdata;
                rfp_pkg::POS_SE:      n_se = i_mem_rdata;
                rfp_pkg::POS_DD_LO:   n_dd[7:0] = i_mem_rdata;
                rfp_pkg::POS_DD_HI:   n_dd[15:8] = i_mem_rdata;
                rfp_pkg::POS_GATE_A:  n_g_a = i_mem_rdata;
                rfp_pkg::POS_GATE_B:  n_g_b = i_mem_rdata;
                rfp_pkg::STEP_TAIL_A: n_ok = r_ok && (i_mem_rdata == rfp_pkg::MARK_TAIL);
                rfp_pkg::STEP_TAIL_B: n_ok = r_ok && (i_mem_rdata == 8'h00);
                default: ;
            endcase
        end

        unique case (r_state)
            rfp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (r_fill < AW'(BUFFER_BYTES - 1)) begin
                        o_mem_we = 1'b1;
                        n_fill   = w_new_len;
                        n_tail   = w_new_tail[23:0];
                        n_len    = w_new_len;
                        n_step   = '0;
                        if (w_new_len >= AW'(rfp_pkg::FOOT_LEN)) begin
                            if (w_new_tail == rfp_pkg::REPORT_FOOT) begin
                                n_fill   = '0;
                                n_is_cmd = 1'b0;
                                n_ok     = (w_new_len >= AW'(rfp_pkg::MIN_REPORT_LEN));
                                n_state  = rfp_pkg::S_READ;
                            end else if (w_new_tail == rfp_pkg::CMD_FOOT) begin
                                n_fill   = '0;
                                n_is_cmd = 1'b1;
                                n_ok     = (w_new_len >= AW'(rfp_pkg::MIN_CMD_LEN));
                                n_state  = rfp_pkg::S_READ;
                            end
                        end
                    end else begin
                        n_fill = '0;
                    end
                end
            end
            rfp_pkg::S_READ: begin
                o_mem_re   = 1'b1;
                n_cap_step = r_step;
                n_cap_vld  = 1'b1;
                if (r_step == w_last_step) begin
                    n_state = rfp_pkg::S_DRAIN;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            rfp_pkg::S_DRAIN: begin
                n_state = rfp_pkg::S_EMIT;
            end
            rfp_pkg::S_EMIT: begin
                n_gate = '0;
                if (r_is_cmd) begin
                    if (w_out_free) begin
                        n_out       = '0;
                        n_out.kind  = r_ok ? rfp_pkg::KIND_ACK_OK : rfp_pkg::KIND_ACK_BAD;
                        n_out.last  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = rfp_pkg::S_IDLE;
                    end
                end else if (!r_ok) begin
                    n_state = rfp_pkg::S_IDLE;
                end else if (w_out_free) begin
                    n_out.kind         = rfp_pkg::KIND_SUMMARY;
                    n_out.tgt_status   = r_ts;
                    n_out.presence     = (r_ts != 8'h00);
                    n_out.move_dist    = r_md;
                    n_out.move_pwr     = r_me;
                    n_out.still_dist   = r_sd;
                    n_out.still_pwr    = r_se;
                    n_out.detect_dist  = r_dd;
                    n_out.engineering  = r_eng;
                    n_out.max_range_cm = r_eng ? w_range : 16'h0000;
                    n_out.gate_index   = '0;
                    n_out.last         = !r_eng;
                    n_out_valid        = 1'b1;
                    n_state = r_eng ? rfp_pkg::S_GATE_MOVE : rfp_pkg::S_IDLE;
                end
            end
            rfp_pkg::S_GATE_MOVE: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(rfp_pkg::GATE_MOVE_BASE) + AW'(r_gate);
                n_state     = rfp_pkg::S_GATE_STILL;
            end
            rfp_pkg::S_GATE_STILL: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(rfp_pkg::GATE_STILL_BASE) + AW'(r_gate);
                n_move      = i_mem_rdata;
                n_state     = rfp_pkg::S_GATE_OUT;
            end
            rfp_pkg::S_GATE_OUT: begin
                if (w_out_free) begin
                    n_out             = '0;
                    n_out.kind        = rfp_pkg::KIND_GATE;
                    n_out.move_pwr    = r_move;
                    n_out.still_pwr   = i_mem_rdata;
                    n_out.engineering = 1'b1;
                    n_out.gate_index  = r_gate;
                    n_out.last        = (r_gate == 4'(GATE_COUNT - 1));
                    n_out_valid       = 1'b1;
                    if (r_gate == 4'(GATE_COUNT - 1)) begin
                        n_state = rfp_pkg::S_IDLE;
                    end else begin
                        n_gate  = r_gate + 4'd1;
                        n_state = rfp_pkg::S_GATE_MOVE;
                    end
                end
            end
            default: n_state = rfp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfp_pkg::S_IDLE;
            r_fill      <= '0;
            r_cap_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_is_cmd    <= 1'b0;
            r_ok        <= 1'b0;
            r_step      <= '0;
            r_gate      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cap_vld   <= n_cap_vld;
            r_out_valid <= n_out_valid;
            r_is_cmd    <= n_is_cmd;
            r_ok        <= n_ok;
            r_step      <= n_step;
            r_gate      <= n_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail     <= n_tail;
        r_len      <= n_len;
        r_cap_step <= n_cap_step;
        r_eng      <= n_eng;
        r_ts       <= n_ts;
        r_md       <= n_md;
        r_me       <= n_me;
        r_sd       <= n_sd;
        r_se       <= n_se;
        r_dd       <= n_dd;
        r_g_a      <= n_g_a;
        r_g_b      <= n_g_b;
        r_move     <= n_move;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
